// ----- rtl/lkmd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Layered key matrix debouncer package
// Command codes and the special key codes used by the debouncer top module.
// ----------------------------------------------------------------------------
package lkmd_pkg;

  // input item command
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_WRITE  = 1'b1
  } command_t;

  // key codes with a meaning of their own
  localparam logic [7:0] CODE_NONE      = 8'h00;
  localparam logic [7:0] CODE_LAYER_ONE = 8'hFD;
  localparam logic [7:0] CODE_LAYER_TWO = 8'hFE;

  // layers selected by the layer keys
  localparam logic [1:0] LAYER_BASE = 2'd0;
  localparam logic [1:0] LAYER_ONE  = 2'd1;
  localparam logic [1:0] LAYER_TWO  = 2'd2;

  // debounce window after reset, in milliseconds
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

endpackage
`default_nettype wire

// ----- rtl/layered_key_matrix_debouncer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Layered key matrix debouncer
// Debounces key-matrix samples per layer entry, handles layer keys and emits
// press and release events; keymap entries are loaded through the input.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    command layer column row level
//                                               time_ms key_code
//   out       output     out_valid / out_ready  event_code pressed active_layer
//   cfg       input      cfg_write_en           cfg_write_data (debounce_ms)
//
// One item per cycle unless a waiting result stalls it: the row memory is
// read as the item is taken, and the compare and write-back work on that
// registered row in the next stage. Reset returns the layer to base, loads the
// window register with its reset value and clears all row valid bits at once,
// with no clearing pass. A waiting result stalls only an item that itself has
// an event, and that item holds in_ready low until the result register frees.
// ----------------------------------------------------------------------------
module layered_key_matrix_debouncer #(
  parameter int LAYERS    = 3,
  parameter int COLUMNS   = 6,
  parameter int ROWS      = 4,
  parameter int TIME_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write_en,
  input  wire  [15:0] cfg_write_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         command,
  input  wire  [1:0]  layer,
  input  wire  [2:0]  column,
  input  wire  [1:0]  row,
  input  wire         level,
  input  wire  [31:0] time_ms,
  input  wire  [7:0]  key_code,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  event_code,
  output logic        pressed,
  output logic [1:0]  active_layer
);

  import lkmd_pkg::*;

  localparam int DEPTH     = COLUMNS * ROWS;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIB       = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int EW        = 1 + TIME_BITS + 8;
  localparam int WIDTH     = LAYERS * EW;

  // configuration and layer state
  logic [15:0] debounce_ms;
  logic [1:0]  current_layer;
  logic [1:0]  current_layer_next;

  // second stage
  logic                 s1_valid;
  logic                 s1_command;
  logic [1:0]           s1_layer;
  logic [ADDR_BITS-1:0] s1_addr;
  logic                 s1_in_range;
  logic                 s1_level;
  logic [TIME_BITS-1:0] s1_now;
  logic [7:0]           s1_key_code;

  logic                 in_transfer;
  logic                 in_range;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [WIDTH-1:0]     rd_data;
  logic                 wr_en;
  logic [WIDTH-1:0]     wr_data;

  logic [EW-1:0]        slot [LAYERS];
  logic [EW-1:0]        slot_next [LAYERS];
  logic                 layer_ok;
  logic [LIB-1:0]       sel;
  logic                 cur_down;
  logic [TIME_BITS-1:0] cur_time;
  logic [7:0]           cur_code;
  logic [TIME_BITS-1:0] elapsed;
  logic                 change_ok;
  logic                 km_write;
  logic                 emit;
  logic                 out_free;
  logic                 s1_done;

  // debounce window register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_write_en) begin
      debounce_ms <= cfg_write_data;
    end
  end

  // input transfer and row address
  assign in_transfer = in_valid && in_ready;
  assign in_range    = (32'(column) < COLUMNS) && (32'(row) < ROWS);
  assign rd_addr     = in_range ? ADDR_BITS'(32'(column) * ROWS + 32'(row)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_transfer) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer) begin
      s1_command  <= command;
      s1_layer    <= layer;
      s1_addr     <= rd_addr;
      s1_in_range <= in_range;
      s1_level    <= level;
      s1_now      <= TIME_BITS'(time_ms);
      s1_key_code <= key_code;
    end
  end

  lkmd_row_mem #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS),
    .WIDTH     (WIDTH)
  ) u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_transfer),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  // split the row into layer entries
  always_comb begin
    for (int l = 0; l < LAYERS; l++) begin
      slot[l] = rd_data[l*EW +: EW];
    end
  end

  // entry of the active layer
  assign layer_ok  = ({1'b0, current_layer} < 3'(LAYERS));
  assign sel       = layer_ok ? LIB'(current_layer) : '0;
  assign cur_down  = slot[sel][EW-1];
  assign cur_time  = slot[sel][8 +: TIME_BITS];
  assign cur_code  = slot[sel][7:0];
  assign elapsed   = s1_now - cur_time;

  // accepted level change and keymap write
  assign change_ok = s1_valid && (s1_command == CMD_SAMPLE) && s1_in_range && layer_ok
                     && (s1_level != cur_down) && (elapsed > TIME_BITS'(debounce_ms));
  assign km_write  = s1_valid && (s1_command == CMD_WRITE) && s1_in_range
                     && ({1'b0, s1_layer} < 3'(LAYERS));
  assign emit      = change_ok && (cur_code != CODE_NONE)
                     && (cur_code != CODE_LAYER_ONE) && (cur_code != CODE_LAYER_TWO);

  assign out_free  = !out_valid || out_ready;
  assign s1_done   = s1_valid && (!emit || out_free);
  assign in_ready  = !s1_valid || s1_done;

  // updated row for write-back
  always_comb begin
    for (int l = 0; l < LAYERS; l++) begin
      slot_next[l] = slot[l];
      if (km_write && (s1_layer == 2'(l))) begin
        slot_next[l][7:0] = s1_key_code;
      end
      if (change_ok && (sel == LIB'(l))) begin
        slot_next[l][EW-1]          = s1_level;
        slot_next[l][8 +: TIME_BITS] = s1_now;
      end
      wr_data[l*EW +: EW] = slot_next[l];
    end
  end

  assign wr_en = s1_done && (change_ok || km_write);

  // layer keys
  always_comb begin
    current_layer_next = current_layer;
    if (s1_done && change_ok) begin
      if (cur_code == CODE_LAYER_ONE) begin
        current_layer_next = s1_level ? LAYER_ONE : LAYER_BASE;
      end else if (cur_code == CODE_LAYER_TWO) begin
        current_layer_next = s1_level ? LAYER_TWO : LAYER_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_layer <= LAYER_BASE;
    end else begin
      current_layer <= current_layer_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && emit) begin
      event_code   <= cur_code;
      pressed      <= s1_level;
      active_layer <= current_layer;
    end
  end

`ifndef ASSERT_OFF
  // an event never carries a silent or layer code
  assert property (@(posedge clk) disable iff (rst)
    (s1_done && emit) |=> (out_valid && (event_code != CODE_NONE)
      && (event_code != CODE_LAYER_ONE) && (event_code != CODE_LAYER_TWO)))
    else $error("event carries a reserved key code");

  // the layer only moves when an item completes
  assert property (@(posedge clk) disable iff (rst)
    !s1_done |=> $stable(current_layer))
    else $error("layer changed without a completed item");

  // row write-back only for a completed in-range item
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_done && s1_in_range))
    else $error("row written without a completed in-range item");

  // the layer never leaves the three selectable values
  assert property (@(posedge clk) disable iff (rst)
    (current_layer == LAYER_BASE) || (current_layer == LAYER_ONE)
    || (current_layer == LAYER_TWO))
    else $error("layer register holds an unreachable value");

  // a stalled item keeps its row data and address
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_done) |=> (s1_valid && $stable(rd_data) && $stable(s1_addr)))
    else $error("stalled item lost its row or address");
`endif

endmodule
`default_nettype wire

// ----- rtl/lkmd_row_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Key row memory
// One row per matrix position holding every layer's entry. Registered read,
// write-first on a same-address clash, and a valid bit per row so that a row
// never written reads as zero after reset.
// ----------------------------------------------------------------------------
module lkmd_row_mem #(
  parameter int DEPTH     = 24,
  parameter int ADDR_BITS = 5,
  parameter int WIDTH     = 123
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  rd_en,
  input  wire [ADDR_BITS-1:0]  rd_addr,
  output logic [WIDTH-1:0]     rd_data,
  input  wire                  wr_en,
  input  wire [ADDR_BITS-1:0]  wr_addr,
  input  wire [WIDTH-1:0]      wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // per-row valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // registered read, new data wins on a clash
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (row_valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule
`default_nettype wire
